>>> hw/rtl/pstb_pkg.sv
// ----------------------------------------------------------------------------
// pstb_pkg: shared definitions of the prescaled soft timer bank
// Field widths, mode codes and reset values used by the timer bank and
// by its port checker.
// ----------------------------------------------------------------------------
package pstb_pkg;

	localparam int MODE_W  = 3;
	localparam int INDEX_W = 3;
	localparam int COUNT_W = 32;
	localparam int REM_W   = 16;
	localparam int LIMIT_W = 16;

	localparam int FAST_COUNT_DEF = 8;
	localparam int SLOW_COUNT_DEF = 8;

	localparam logic [LIMIT_W-1:0] PRESCALE_RESET = 16'd4410;

	localparam logic [MODE_W-1:0] MODE_TICK        = 3'd0;
	localparam logic [MODE_W-1:0] MODE_RELOAD_FAST = 3'd1;
	localparam logic [MODE_W-1:0] MODE_RELOAD_SLOW = 3'd2;
	localparam logic [MODE_W-1:0] MODE_QUERY_FAST  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_QUERY_SLOW  = 3'd4;

endpackage

>>> hw/rtl/prescaled_soft_timer_bank.sv
// ----------------------------------------------------------------------------
// prescaled_soft_timer_bank: two banks of one-shot 32-bit down-counters
// A fast bank steps on every tick; a slow bank steps once every
// prescale_limit+1 ticks through a 16-bit prescaler. Reload and query
// transfers reach one counter of either bank.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+------------------------------
//  cfg      | in        | cfg_valid / cfg_ready | prescale_limit[15:0]
//  in       | in        | in_valid  / in_ready  | mode, timer_index, load_value
//  out      | out       | out_valid / out_ready | remaining[15:0], expired
//
//  One item per cycle, unless a query is held by a stall on out_ready. A
//  transfer lands in the input register; from there it is applied to the
//  counters, and a query's result is written into the output register.
//  Reset clears every counter and the prescaler, and sets the limit to 4410.
//  A stall on out_ready holds only a query waiting in the input register
//  and the items behind it; other ticks and reloads pass a full output register.
//  cfg_ready is always high; a write takes effect at the edge of its transfer.
//
module prescaled_soft_timer_bank #(
	parameter int FAST_COUNT = pstb_pkg::FAST_COUNT_DEF,
	parameter int SLOW_COUNT = pstb_pkg::SLOW_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pstb_pkg::LIMIT_W-1:0]   prescale_limit,
	// item input
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [pstb_pkg::MODE_W-1:0]    mode,
	input  logic [pstb_pkg::INDEX_W-1:0]   timer_index,
	input  logic [pstb_pkg::COUNT_W-1:0]   load_value,
	// query results
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [pstb_pkg::REM_W-1:0]     remaining,
	output logic                           expired
);

	// Select widths; a single-counter bank still gets a one-bit select.
	localparam int FAST_IW = (FAST_COUNT > 1) ? $clog2(FAST_COUNT) : 1;
	localparam int SLOW_IW = (SLOW_COUNT > 1) ? $clog2(SLOW_COUNT) : 1;

	// Configuration register: always ready, written on transfer.
	logic [pstb_pkg::LIMIT_W-1:0] prescale_limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_limit_q <= pstb_pkg::PRESCALE_RESET;
		end else if (cfg_valid) begin
			prescale_limit_q <= prescale_limit;
		end
	end

	// Input register
	logic                           valid_s1;
	logic [pstb_pkg::MODE_W-1:0]    mode_s1;
	logic [pstb_pkg::INDEX_W-1:0]   index_s1;
	logic [pstb_pkg::COUNT_W-1:0]   load_s1;
	logic                           in_xfer;
	logic                           adv_s1;

	// Decoded operation of the held item
	logic do_tick;
	logic do_reload_fast;
	logic do_reload_slow;
	logic do_query_fast;
	logic do_query_slow;
	logic do_query;

	always_comb begin
		do_tick        = 1'b0;
		do_reload_fast = 1'b0;
		do_reload_slow = 1'b0;
		do_query_fast  = 1'b0;
		do_query_slow  = 1'b0;
		unique case (mode_s1)
			pstb_pkg::MODE_TICK:        do_tick        = 1'b1;
			pstb_pkg::MODE_RELOAD_FAST: do_reload_fast = 1'b1;
			pstb_pkg::MODE_RELOAD_SLOW: do_reload_slow = 1'b1;
			pstb_pkg::MODE_QUERY_FAST:  do_query_fast  = 1'b1;
			pstb_pkg::MODE_QUERY_SLOW:  do_query_slow  = 1'b1;
			default: ;  // unused codes: drop the item without effect
		endcase
	end

	assign do_query = do_query_fast | do_query_slow;

	// Output register
	logic                         out_valid_q;
	logic [pstb_pkg::REM_W-1:0]   remaining_q;
	logic                         expired_q;

	// Only a query needs the output register to be free.
	assign adv_s1   = valid_s1 & (~do_query | ~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | adv_s1;
	assign in_xfer  = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mode_s1  <= mode;
			index_s1 <= timer_index;
			load_s1  <= load_value;
		end
	end

	// Index range checks and counter selects
	logic               fast_hit;
	logic               slow_hit;
	logic [FAST_IW-1:0] fast_sel;
	logic [SLOW_IW-1:0] slow_sel;

	assign fast_hit = int'(index_s1) < FAST_COUNT;
	assign slow_hit = int'(index_s1) < SLOW_COUNT;
	assign fast_sel = FAST_IW'(index_s1);
	assign slow_sel = SLOW_IW'(index_s1);

	// Prescaler: the slow bank steps when the old value has reached the limit.
	logic [pstb_pkg::LIMIT_W-1:0] prescaler_q;
	logic                         slow_step;

	assign slow_step = prescaler_q >= prescale_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescaler_q <= '0;
		end else if (adv_s1 && do_tick) begin
			prescaler_q <= slow_step ? '0 : prescaler_q + 1'b1;
		end
	end

	// Counter banks: each counter has its own decrementer and reload path.
	logic [pstb_pkg::COUNT_W-1:0] fast_cnt_q [FAST_COUNT];
	logic [pstb_pkg::COUNT_W-1:0] slow_cnt_q [SLOW_COUNT];

	for (genvar i = 0; i < FAST_COUNT; i++) begin : g_fast
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				fast_cnt_q[i] <= '0;
			end else if (adv_s1) begin
				if (do_tick && fast_cnt_q[i] != '0) begin
					fast_cnt_q[i] <= fast_cnt_q[i] - 1'b1;
				end else if (do_reload_fast && fast_hit && fast_sel == FAST_IW'(i)) begin
					fast_cnt_q[i] <= load_s1;
				end
			end
		end
	end

	for (genvar i = 0; i < SLOW_COUNT; i++) begin : g_slow
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				slow_cnt_q[i] <= '0;
			end else if (adv_s1) begin
				if (do_tick && slow_step && slow_cnt_q[i] != '0) begin
					slow_cnt_q[i] <= slow_cnt_q[i] - 1'b1;
				end else if (do_reload_slow && slow_hit && slow_sel == SLOW_IW'(i)) begin
					slow_cnt_q[i] <= load_s1;
				end
			end
		end
	end

	// Query read: an index beyond the bank reads as zero, hence expired.
	logic [pstb_pkg::COUNT_W-1:0] fast_rd;
	logic [pstb_pkg::COUNT_W-1:0] slow_rd;
	logic [pstb_pkg::COUNT_W-1:0] query_rd;

	assign fast_rd  = fast_hit ? fast_cnt_q[fast_sel] : '0;
	assign slow_rd  = slow_hit ? slow_cnt_q[slow_sel] : '0;
	assign query_rd = do_query_slow ? slow_rd : fast_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && do_query) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Expired comes from the full count, not from the truncated value.
	always_ff @(posedge clk) begin
		if (adv_s1 && do_query) begin
			remaining_q <= query_rd[pstb_pkg::REM_W-1:0];
			expired_q   <= (query_rd == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign remaining = remaining_q;
	assign expired   = expired_q;

endmodule

>>> hw/rtl/pstb_checker.sv
// ----------------------------------------------------------------------------
// pstb_checker: port checks for the prescaled soft timer bank
// Watches the ports of the timer bank over time; attached by bind.
// ----------------------------------------------------------------------------
module pstb_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic [pstb_pkg::LIMIT_W-1:0]   prescale_limit,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic [pstb_pkg::MODE_W-1:0]    mode,
	input logic [pstb_pkg::INDEX_W-1:0]   timer_index,
	input logic [pstb_pkg::COUNT_W-1:0]   load_value,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [pstb_pkg::REM_W-1:0]     remaining,
	input logic                           expired
);

	logic query_xfer;

	assign query_xfer = in_valid && in_ready &&
		(mode == pstb_pkg::MODE_QUERY_FAST || mode == pstb_pkg::MODE_QUERY_SLOW);

	// Hold a stalled result.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(remaining) && $stable(expired))
		else $error("result changed while stalled");

	// A fresh result must follow an earlier query transfer.
	a_out_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(query_xfer, 2))
		else $error("result without a query transfer");

	// A zero count has zero low bits.
	a_expired_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && expired |-> remaining == '0)
		else $error("expired result with nonzero remaining");

	// Input back-pressure only comes from a full, stalled output.
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output stall");

	// Configuration writes never wait.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write held off");

endmodule

bind prescaled_soft_timer_bank pstb_checker u_pstb_checker (.*);
